@@ hw/rtl/cigar_chimera_flag_rewrite_assert.svh @@
// Assertion macros shared by the CIGAR chimera flag rewrite block.
`ifndef CIGAR_CHIMERA_FLAG_REWRITE_ASSERT_SVH
`define CIGAR_CHIMERA_FLAG_REWRITE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ccfr_pkg.sv @@
// Types, constants and codes of the CIGAR chimera flag rewrite block.
package ccfr_pkg;

   // Width of the saturating run length counters.
   localparam int LEN_BITS     = 24;
   localparam int OUT_LEN_BITS = 24;
   localparam int CMP_BITS     = (LEN_BITS > OUT_LEN_BITS) ? LEN_BITS : OUT_LEN_BITS;
   localparam int PROD_BITS    = OUT_LEN_BITS + 7;

   localparam logic [LEN_BITS-1:0]     LEN_MAX     = {LEN_BITS{1'b1}};
   localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = {OUT_LEN_BITS{1'b1}};

   // Chimera threshold: 100 * longest < 44 * read length.
   localparam logic [6:0] CHIM_SCALE_MATCH = 7'd100;
   localparam logic [6:0] CHIM_SCALE_READ  = 7'd44;

   // Flag word bits.
   localparam logic [15:0] FLAG_PROPER   = 16'h0002;
   localparam logic [15:0] FLAG_UNMAPPED = 16'h0004;
   localparam logic [15:0] FLAG_QCFAIL   = 16'h0200;

   // CIGAR characters of interest.
   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_M  = 8'h4D;
   localparam logic [7:0] CHAR_EQ = 8'h3D;
   localparam logic [7:0] CHAR_X  = 8'h58;

   // Strand codes.
   localparam logic [1:0] STRAND_NONE = 2'd0;
   localparam logic [1:0] STRAND_BAD  = 2'd3;

   // Configuration register indexes.
   typedef enum logic {
      CSR_FAILED_STRAND = 1'b0,
      CSR_SKIP_CHIMERA  = 1'b1
   } csr_index_type;

   // Input transaction kinds.
   typedef enum logic {
      ACT_CHAR   = 1'b0,
      ACT_RECORD = 1'b1
   } action_type;

   // Controls from the input stage to the parser.
   typedef struct packed {
      logic       char_en;
      logic       clear;
      logic [7:0] ch;
   } parse_ctrl_type;

   // Parser status seen by the rewrite stage.
   typedef struct packed {
      logic                    bad;
      logic                    digits;
      logic [OUT_LEN_BITS-1:0] longest;
   } parse_status_type;

   // Fields of an end-of-record transaction.
   typedef struct packed {
      logic [15:0] flag;
      logic [7:0]  mapq;
      logic [23:0] read_length;
      logic [1:0]  strand_tag;
   } record_type;

   // Configuration values.
   typedef struct packed {
      logic [1:0] failed_strand;
      logic       skip_chimera;
   } cfg_type;

endpackage

@@ hw/rtl/ccfr_parser.sv @@
// CIGAR run length parser tracking the longest M, = or X run.
module ccfr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  ccfr_pkg::parse_ctrl_type   ctrl,
   output ccfr_pkg::parse_status_type status
);
   import ccfr_pkg::*;

   logic [LEN_BITS-1:0] run_ff, run_in;
   logic [LEN_BITS-1:0] longest_ff, longest_in;
   logic                digits_ff, digits_in;
   logic                bad_ff, bad_in;

   logic                is_digit;
   logic                is_match_op;
   logic [3:0]          digit_val;
   logic [LEN_BITS+3:0] run_next;
   logic [CMP_BITS-1:0] longest_ext;

   // Character classification and the decimal accumulate.
   assign is_digit    = (ctrl.ch >= CHAR_0) && (ctrl.ch <= CHAR_9);
   assign is_match_op = (ctrl.ch == CHAR_M) || (ctrl.ch == CHAR_EQ) || (ctrl.ch == CHAR_X);
   assign digit_val   = 4'(ctrl.ch - CHAR_0);
   assign run_next    = ({4'b0, run_ff} << 3) + ({4'b0, run_ff} << 1)
                        + (LEN_BITS+4)'(digit_val);

   // Next parser state.
   always_comb begin
      run_in     = run_ff;
      longest_in = longest_ff;
      digits_in  = digits_ff;
      bad_in     = bad_ff;
      if (ctrl.clear) begin
         run_in     = '0;
         longest_in = '0;
         digits_in  = 1'b0;
         bad_in     = 1'b0;
      end else if (ctrl.char_en && !bad_ff) begin
         if (is_digit) begin
            run_in    = (run_next > (LEN_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                           : run_next[LEN_BITS-1:0];
            digits_in = 1'b1;
         end else if (!digits_ff) begin
            bad_in = 1'b1;
         end else begin
            if (is_match_op && (run_ff > longest_ff)) begin
               longest_in = run_ff;
            end
            run_in    = '0;
            digits_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         longest_ff <= '0;
         digits_ff  <= 1'b0;
         bad_ff     <= 1'b0;
      end else begin
         run_ff     <= run_in;
         longest_ff <= longest_in;
         digits_ff  <= digits_in;
         bad_ff     <= bad_in;
      end
   end

   // Longest match as reported: zero for a malformed CIGAR or a trailing number, else saturated to the output width.
   assign longest_ext = CMP_BITS'(longest_ff);

   always_comb begin
      status.bad    = bad_ff;
      status.digits = digits_ff;
      if (bad_ff || digits_ff) begin
         status.longest = '0;
      end else if (longest_ext > CMP_BITS'(OUT_LEN_MAX)) begin
         status.longest = OUT_LEN_MAX;
      end else begin
         status.longest = longest_ext[OUT_LEN_BITS-1:0];
      end
   end

endmodule

@@ hw/rtl/ccfr_rewrite.sv @@
// Flag and MAPQ rewrite logic with the result register.
module ccfr_rewrite (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  ccfr_pkg::record_type       rec,
   input  ccfr_pkg::parse_status_type status,
   input  ccfr_pkg::cfg_type          cfg,
   input  logic                       out_ready,
   output logic                       room,
   output logic                       out_valid,
   output logic [15:0]                flag_out,
   output logic [7:0]                 mapq_out,
   output logic                       mapped_out,
   output logic [1:0]                 strand_out,
   output logic [ccfr_pkg::OUT_LEN_BITS-1:0] longest_out
);
   import ccfr_pkg::*;

   logic                    valid_ff, valid_in;
   logic [15:0]             flag_ff, flag_in;
   logic [7:0]              mapq_ff, mapq_in;
   logic                    mapped_ff, mapped_in;
   logic [1:0]              strand_ff, strand_in;
   logic [OUT_LEN_BITS-1:0] longest_ff;

   logic                    qc_strand;
   logic                    chimera;
   logic [PROD_BITS-1:0]    match_scaled;
   logic [PROD_BITS-1:0]    read_scaled;

   // The result register can take a new record when empty or being drained.
   assign room = !valid_ff || out_ready;

   // Strand, mapped state and the two QC-fail rules.
   assign strand_in    = (rec.strand_tag == STRAND_BAD) ? STRAND_NONE : rec.strand_tag;
   assign mapped_in    = ((rec.flag & FLAG_UNMAPPED) == 16'h0000) && (strand_in != STRAND_NONE);
   assign qc_strand    = mapped_in && (cfg.failed_strand != STRAND_NONE)
                         && (cfg.failed_strand == strand_in);
   assign match_scaled = PROD_BITS'(status.longest) * PROD_BITS'(CHIM_SCALE_MATCH);
   assign read_scaled  = PROD_BITS'(rec.read_length) * PROD_BITS'(CHIM_SCALE_READ);
   assign chimera      = mapped_in && !cfg.skip_chimera && (rec.read_length != 24'd0)
                         && (match_scaled < read_scaled);

   always_comb begin
      flag_in = rec.flag;
      mapq_in = rec.mapq;
      if (qc_strand) begin
         flag_in = flag_in | FLAG_QCFAIL;
      end
      if (chimera) begin
         flag_in = (flag_in | FLAG_QCFAIL) & ~FLAG_PROPER;
         if (mapq_in > 8'd1) begin
            mapq_in = 8'd1;
         end
      end
   end

   // Result valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         flag_ff    <= flag_in;
         mapq_ff    <= mapq_in;
         mapped_ff  <= mapped_in;
         strand_ff  <= strand_in;
         longest_ff <= status.longest;
      end
   end

   assign out_valid   = valid_ff;
   assign flag_out    = flag_ff;
   assign mapq_out    = mapq_ff;
   assign mapped_out  = mapped_ff;
   assign strand_out  = strand_ff;
   assign longest_out = longest_ff;

endmodule

@@ hw/rtl/cigar_chimera_flag_rewrite.sv @@
// Top level of the CIGAR chimera flag rewrite block.
//
//   Channel  Direction  Carries
//   req_     in         one CIGAR character or one end-of-record transaction
//   rsp_     out        rewritten flag, MAPQ, mapped, strand, longest match
//   csr_     in         configuration write (index, data)
//
// One transaction is accepted per cycle unless a record waits for result room.
// A record passes through the input register and then the result register, which
// presents its result on rsp_. Character transactions produce no result. Reset is
// synchronous and clears the parser, the configuration and both valid flags. A stalled
// result holds the result register and, through it, the next record's input register.
`include "cigar_chimera_flag_rewrite_assert.svh"

module cigar_chimera_flag_rewrite (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // cigar_char[7:0], flag_in[23:8], mapq_in[31:24],
                                   // read_length[55:32], ref_strand_tag[57:56], zero
   input  logic        req_tuser,  // action[0]
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // flag_out[15:0], mapq_out[23:16], mapped[24],
                                   // strand_out[26:25], longest_match[50:27], zero
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);
   import ccfr_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   action_type  s1_action_ff;
   logic [57:0] s1_data_ff;
   logic        s1_adv;
   logic        req_fire;
   logic        out_room;
   logic        rec_load;

   cfg_type          cfg_ff, cfg_in;
   parse_ctrl_type   pctrl;
   parse_status_type pstat;
   record_type       rec;

   logic [15:0]             rsp_flag;
   logic [7:0]              rsp_mapq;
   logic                    rsp_mapped;
   logic [1:0]              rsp_strand;
   logic [OUT_LEN_BITS-1:0] rsp_longest;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAILED_STRAND: cfg_in.failed_strand = csr_data;
            CSR_SKIP_CHIMERA:  cfg_in.skip_chimera  = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: a character always moves on, a record waits for result room.
   assign s1_adv     = s1_valid_ff && ((s1_action_ff == ACT_CHAR) || out_room);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign rec_load   = s1_adv && (s1_action_ff == ACT_RECORD);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= action_type'(req_tuser);
         s1_data_ff   <= req_tdata[57:0];
      end
   end

   // Parser controls and record fields from the input register.
   assign pctrl.char_en   = s1_adv && (s1_action_ff == ACT_CHAR);
   assign pctrl.clear     = rec_load;
   assign pctrl.ch        = s1_data_ff[7:0];
   assign rec.flag        = s1_data_ff[23:8];
   assign rec.mapq        = s1_data_ff[31:24];
   assign rec.read_length = s1_data_ff[55:32];
   assign rec.strand_tag  = s1_data_ff[57:56];

   ccfr_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (pctrl),
      .status (pstat)
   );

   ccfr_rewrite u_rewrite (
      .clock       (clock),
      .reset       (reset),
      .load        (rec_load),
      .rec         (rec),
      .status      (pstat),
      .cfg         (cfg_ff),
      .out_ready   (rsp_tready),
      .room        (out_room),
      .out_valid   (rsp_tvalid),
      .flag_out    (rsp_flag),
      .mapq_out    (rsp_mapq),
      .mapped_out  (rsp_mapped),
      .strand_out  (rsp_strand),
      .longest_out (rsp_longest)
   );

   // Result packing.
   assign rsp_tdata = {5'b0, rsp_longest, rsp_strand, rsp_mapped, rsp_mapq, rsp_flag};

   // A character transaction never makes a result appear.
   `CCFR_ASSERT_NEXT(a_char_no_result, clock, reset,
      pctrl.char_en && !rsp_tvalid, !rsp_tvalid,
      "result appeared after a character transaction")

   // The parser is empty right after a record was consumed.
   `CCFR_ASSERT_NEXT(a_parser_cleared, clock, reset,
      rec_load, !pstat.bad && !pstat.digits && (pstat.longest == '0),
      "parser not cleared after end of record")

   // A mapped result always carries a real strand.
   `CCFR_ASSERT_NOW(a_mapped_strand, clock, reset,
      rsp_tvalid && rsp_mapped, (rsp_strand != STRAND_NONE) && (rsp_strand != STRAND_BAD),
      "mapped result without a valid strand")

   // A record only loads when the result register is empty or being drained.
   `CCFR_ASSERT_NOW(a_record_room, clock, reset,
      rec_load, !rsp_tvalid || rsp_tready,
      "record loaded while the result register was full")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the CIGAR chimera flag rewrite block.
`timescale 1ns / 1ps

module testbench;
   import ccfr_pkg::*;

   // Strand codes that the package leaves unnamed.
   localparam logic [1:0] STRAND_FWD = 2'd1;
   localparam logic [1:0] STRAND_REV = 2'd2;

   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 225;

   // One input transaction: a CIGAR character or an end-of-record.
   typedef struct packed {
      action_type action;
      logic [7:0] ch;
      record_type rec;
   } req_item_type;

   // One result transaction.
   typedef struct packed {
      logic [15:0] flag;
      logic [7:0]  mapq;
      logic        mapped;
      logic [1:0]  strand;
      logic [23:0] longest;
   } rewrite_type;

   // One row of the directed table; typed rows carry their result inline.
   typedef struct packed {
      req_item_type item;
      logic         typed;
      rewrite_type  result;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [1:0]  csr_data   = '0;

   // Parser and configuration state of the predictor.
   longint unsigned run_len     = 0;
   longint unsigned longest_run = 0;
   bit              digits_seen = 1'b0;
   bit              cigar_bad   = 1'b0;
   logic [1:0]      cfg_failed_strand = STRAND_NONE;
   logic            cfg_skip_chimera  = 1'b0;

   rewrite_type      pending_rewrites[$];
   directed_row_type directed_rows[$];

   int error_count  = 0;
   int items_sent   = 0;
   int burst_left   = 0;
   int steady_left  = 0;
   int stall_cycles = 0;
   bit hold_off_req = 1'b0;

   cigar_chimera_flag_rewrite u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the CIGAR parser by one character.
   function automatic void parse_cigar_char(input logic [7:0] ch);
      longint unsigned next_len;
      if (cigar_bad) return;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
         next_len    = run_len * 10 + longint'(ch - CHAR_0);
         run_len     = (next_len > LEN_MAX) ? longint'(LEN_MAX) : next_len;
         digits_seen = 1'b1;
         return;
      end
      // A non-digit with no run length in front makes the CIGAR malformed.
      if (!digits_seen) begin
         cigar_bad = 1'b1;
         return;
      end
      if ((ch == CHAR_M || ch == CHAR_EQ || ch == CHAR_X) && run_len > longest_run)
         longest_run = run_len;
      run_len     = 0;
      digits_seen = 1'b0;
   endfunction

   // Rewrite one record from the parser state, then clear the parser.
   function automatic rewrite_type rewrite_record(input record_type rec);
      rewrite_type     r;
      logic [1:0]      strand;
      longint unsigned lm;
      logic            on_map;
      strand = (rec.strand_tag == STRAND_BAD) ? STRAND_NONE : rec.strand_tag;
      // A malformed CIGAR or a trailing number gives no longest match.
      lm = (cigar_bad || digits_seen) ? 0 : longest_run;
      if (lm > OUT_LEN_MAX) lm = 64'(OUT_LEN_MAX);
      on_map = ((rec.flag & FLAG_UNMAPPED) == 0) && (strand != STRAND_NONE);
      r.flag = rec.flag;
      r.mapq = rec.mapq;
      if (on_map && cfg_failed_strand != STRAND_NONE && cfg_failed_strand == strand)
         r.flag = r.flag | FLAG_QCFAIL;
      // Chimera rule: the longest match covers under 44% of the read.
      if (on_map && !cfg_skip_chimera && rec.read_length != 0 &&
          longint'(CHIM_SCALE_MATCH) * lm <
          longint'(CHIM_SCALE_READ) * longint'(rec.read_length)) begin
         r.flag = (r.flag | FLAG_QCFAIL) & ~FLAG_PROPER;
         if (r.mapq > 8'd1) r.mapq = 8'd1;
      end
      r.mapped    = on_map;
      r.strand    = strand;
      r.longest   = lm[23:0];
      run_len     = 0;
      digits_seen = 1'b0;
      longest_run = 0;
      cigar_bad   = 1'b0;
      return r;
   endfunction

   // Offer one transaction, with bursts and gaps, and predict it on acceptance.
   task automatic offer(input req_item_type it, input logic typed, input rewrite_type result);
      rewrite_type predicted;
      if (steady_left > 0) begin
         steady_left--;
      end else if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(50, 150);
      end else begin
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {6'b0, it.rec.strand_tag, it.rec.read_length, it.rec.mapq,
                     it.rec.flag, it.ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (it.action == ACT_CHAR) begin
         parse_cigar_char(it.ch);
      end else begin
         predicted = rewrite_record(it.rec);
         pending_rewrites.push_back(typed ? result : predicted);
      end
   endtask

   // Character transaction with random content in the unused fields.
   task automatic send_char(input logic [7:0] ch);
      req_item_type it;
      it.action              = ACT_CHAR;
      it.ch                  = ch;
      it.rec.flag            = 16'($urandom);
      it.rec.mapq            = 8'($urandom);
      it.rec.read_length     = 24'($urandom);
      it.rec.strand_tag      = 2'($urandom);
      offer(it, 1'b0, '0);
   endtask

   task automatic send_record(input record_type rec);
      req_item_type it;
      it.action = ACT_RECORD;
      it.ch     = 8'($urandom_range(0, 255));
      it.rec    = rec;
      offer(it, 1'b0, '0);
   endtask

   // Stop offering and wait until every pending result has arrived.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rewrites.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FAILED_STRAND: cfg_failed_strand = value;
         CSR_SKIP_CHIMERA:  cfg_skip_chimera  = value[0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Configuration is only changed once the block has gone quiet.
   task automatic configure(input logic [1:0] failed, input logic skip);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_FAILED_STRAND, failed);
      write_csr(CSR_SKIP_CHIMERA, {1'b0, skip});
   endtask

   // One random record: mostly well-formed CIGARs, some broken, some noise.
   task automatic send_random_record();
      string           ops;
      string           bad_chars;
      string           digits;
      int              kind, n_ops, bad_at, i, k, sel;
      longint unsigned len, gen_longest, rlen;
      logic [7:0]      op;
      record_type      rec;
      ops         = "MIDNSHP=X";
      bad_chars   = "*+- MX=";
      gen_longest = 0;
      kind        = $urandom_range(0, 99);
      if (kind < 90) begin
         n_ops  = $urandom_range(0, 6);
         bad_at = (n_ops > 0) ? $urandom_range(0, n_ops - 1) : 0;
         for (i = 0; i < n_ops; i++) begin
            // A character with no run length in front breaks the CIGAR.
            if (kind >= 74 && kind < 82 && i == bad_at)
               send_char(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
            sel = $urandom_range(0, 19);
            if (sel == 0)      len = 64'($urandom_range(16777200, 16777215));
            else if (sel == 1) len = 64'($urandom_range(99999999, 999999999));
            else if (sel < 8)  len = 64'($urandom_range(1, 9));
            else               len = 64'($urandom_range(1, 500));
            if ($urandom_range(0, 15) == 0) send_char(CHAR_0);
            digits = $sformatf("%0d", len);
            for (k = 0; k < digits.len(); k++) send_char(digits[k]);
            // Leave the last run without its operation: a trailing number.
            if (kind >= 82 && i == n_ops - 1) break;
            op = ops[$urandom_range(0, 8)];
            send_char(op);
            if (len > LEN_MAX) len = 64'(LEN_MAX);
            if ((op == CHAR_M || op == CHAR_EQ || op == CHAR_X) && len > gen_longest)
               gen_longest = len;
         end
      end else begin
         repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
      end
      // Read length near the 44% threshold, at it, or anywhere.
      sel = $urandom_range(0, 9);
      if (sel == 0)      rlen = 0;
      else if (sel == 1) rlen = 64'($urandom_range(0, 16777215));
      else if (sel == 2) rlen = gen_longest * 100 / 44;
      else if (sel == 3) rlen = gen_longest * 100 / 44 + 1;
      else               rlen = gen_longest * 100 / $urandom_range(20, 90) + $urandom_range(0, 3);
      if (rlen > OUT_LEN_MAX) rlen = 64'(OUT_LEN_MAX);
      rec.flag = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) != 0) rec.flag = rec.flag & ~FLAG_UNMAPPED;
      rec.mapq = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1))
                                             : 8'($urandom_range(0, 255));
      rec.read_length = rlen[23:0];
      sel = $urandom_range(0, 9);
      if (sel == 0)      rec.strand_tag = STRAND_NONE;
      else if (sel == 1) rec.strand_tag = STRAND_BAD;
      else               rec.strand_tag = sel[0] ? STRAND_FWD : STRAND_REV;
      send_record(rec);
   endtask

   task automatic add_char(input logic [7:0] ch);
      directed_row_type row;
      row.item.action = ACT_CHAR;
      row.item.ch     = ch;
      row.item.rec    = '0;
      row.typed       = 1'b0;
      row.result      = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_chars(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic add_record(input logic [15:0] flag, input logic [7:0] mapq,
                             input logic [23:0] rlen, input logic [1:0] strand,
                             input logic typed, input rewrite_type result);
      directed_row_type row;
      row.item.action = ACT_RECORD;
      row.item.ch     = 8'h00;
      row.item.rec    = {flag, mapq, rlen, strand};
      row.typed       = typed;
      row.result      = result;
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Compare each accepted result with the oldest pending one.
   always @(posedge clock) begin : result_check
      rewrite_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rewrites.size() == 0) begin
            $error("result transaction with none pending: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_rewrites.pop_front();
            check_field("flag_out", want.flag, rsp_tdata[15:0]);
            check_field("mapq_out", want.mapq, rsp_tdata[23:16]);
            check_field("mapped", want.mapped, rsp_tdata[24]);
            check_field("strand_out", want.strand, rsp_tdata[26:25]);
            check_field("longest_match", want.longest, rsp_tdata[50:27]);
         end
      end
   end

   // End the run when no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: random ready pattern, plus a long hold-off on request.
   initial begin : receiver
      int   span;
      int   sel;
      logic level;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            level        = 1'b0;
            span         = HOLD_CYCLES;
         end else begin
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
               level = 1'b1;
               span  = $urandom_range(30, 150);
            end else if (sel < 6) begin
               level = 1'b1;
               span  = $urandom_range(1, 6);
            end else begin
               level = 1'b0;
               span  = $urandom_range(1, 5);
            end
         end
         repeat (span) begin
            @(negedge clock);
            rsp_tready <= level;
         end
      end
   end

   initial begin : stimulus
      int         phase, phase_start;
      bit         hold_done, pause_done;
      logic [1:0] failed;
      logic       skip;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, run at the reset configuration.
      add_record(16'h0000, 8'd60, 24'd0, STRAND_FWD, 1'b1,
                 {16'h0000, 8'd60, 1'b1, STRAND_FWD, 24'd0});
      add_chars("*");
      add_record(FLAG_UNMAPPED, 8'd255, 24'd100, STRAND_REV, 1'b1,
                 {FLAG_UNMAPPED, 8'd255, 1'b0, STRAND_REV, 24'd0});
      add_chars("10M5S");
      add_record(FLAG_PROPER, 8'd30, 24'd100, STRAND_FWD, 1'b0, '0);
      add_chars("99999999X");
      add_record(16'hFFFB, 8'd255, 24'hFFFFFF, STRAND_REV, 1'b0, '0);
      add_chars("5=12");
      add_record(16'h0012, 8'd7, 24'd50, STRAND_BAD, 1'b1,
                 {16'h0012, 8'd7, 1'b0, STRAND_NONE, 24'd0});
      add_char(8'h00);
      add_record(16'hFFFF, 8'd0, 24'd1, STRAND_FWD, 1'b1,
                 {16'hFFFF, 8'd0, 1'b0, STRAND_FWD, 24'd0});
      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

      // Random phases, each under its own configuration.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin failed = STRAND_NONE; skip = 1'b0; end
            1:       begin failed = STRAND_FWD;  skip = 1'b0; end
            2:       begin failed = STRAND_REV;  skip = 1'b0; end
            3:       begin failed = STRAND_BAD;  skip = 1'b0; end
            4:       begin failed = STRAND_REV;  skip = 1'b1; end
            5:       begin failed = STRAND_FWD;  skip = 1'b1; end
            6:       begin failed = STRAND_NONE; skip = 1'b1; end
            default: begin
               failed = 2'($urandom_range(0, 3));
               skip   = 1'($urandom_range(0, 1));
            end
         endcase
         configure(failed, skip);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // Back up the block: the receiver holds off while items keep coming.
            if (phase == 2 && !hold_done && items_sent - phase_start >= 40) begin
               hold_off_req = 1'b1;
               steady_left  = 300;
               hold_done    = 1'b1;
            end
            // Let the pipeline run empty in the middle of a phase.
            if (phase == 3 && !pause_done && items_sent - phase_start >= 100) begin
               drain();
               pause_done = 1'b1;
            end
            send_random_record();
         end
      end

      drain();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ cigar_chimera_flag_rewrite.f @@
+incdir+hw/rtl
hw/rtl/ccfr_pkg.sv
hw/rtl/ccfr_parser.sv
hw/rtl/ccfr_rewrite.sv
hw/rtl/cigar_chimera_flag_rewrite.sv
tb/testbench.sv
